// File: rtl/core/polar_normal_random_generator_unit_assert.svh
// Assertion macros for the polar normal generator checker.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef POLAR_NORMAL_RANDOM_GENERATOR_UNIT_ASSERT_SVH
`define POLAR_NORMAL_RANDOM_GENERATOR_UNIT_ASSERT_SVH

// antecedent in this cycle implies consequent in the next cycle
`define PNRG_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("pnrg assertion failed");

// antecedent implies consequent in the same cycle
`define PNRG_ASSERT_NOW(label, ante, cons) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("pnrg assertion failed");

`endif

// File: rtl/core/pnrg_pkg.sv
// Shared constants, datapath op codes and control/status structs
// for the polar normal generator. No dependencies.
`default_nettype none
package pnrg_pkg;

   // sample format and derived widths
   localparam int FRAC_W   = 16;
   localparam int SAMPLE_W = FRAC_W + 4;
   localparam int PROD_W   = 66;
   localparam int S_SHIFT  = 58 - 2 * FRAC_W;
   localparam int S_W      = PROD_W - S_SHIFT;
   localparam int ROOT_W   = S_W / 2;
   localparam int SQC_W    = $clog2(ROOT_W);

   localparam logic [ROOT_W:0] SAT_NEG = (ROOT_W + 1)'(1) << (FRAC_W + 3);
   localparam logic [ROOT_W:0] SAT_POS = SAT_NEG - (ROOT_W + 1)'(1);
   localparam logic [SQC_W-1:0] SQ_LAST = SQC_W'(ROOT_W - 1);

   // generator constants
   localparam logic [31:0] LCG_MUL      = 32'd1103515245;
   localparam logic [31:0] LCG_ADD      = 32'd12345;
   localparam logic [31:0] SEED_RESET   = 32'd3;
   localparam logic [10:0] STRIDE_RESET = 11'd4;
   localparam logic [29:0] LN2_Q30      = 30'd744261118;
   localparam logic [3:0]  LOG_LAST     = 4'd11;
   localparam logic [4:0]  Z_BITS       = 5'd30;
   localparam logic [4:0]  R_BITS       = 5'd29;

   // register indexes
   localparam logic [1:0] CSR_SEED   = 2'd0;
   localparam logic [1:0] CSR_STRIDE = 2'd1;

   // datapath op codes
   localparam logic [4:0] OP_NONE       = 5'd0;
   localparam logic [4:0] OP_RELOAD     = 5'd1;
   localparam logic [4:0] OP_STEP1      = 5'd2;
   localparam logic [4:0] OP_STEP2      = 5'd3;
   localparam logic [4:0] OP_SQ         = 5'd4;
   localparam logic [4:0] OP_NORM_INIT  = 5'd5;
   localparam logic [4:0] OP_NORM_SHIFT = 5'd6;
   localparam logic [4:0] OP_ZDIV       = 5'd7;
   localparam logic [4:0] OP_ZCAP       = 5'd8;
   localparam logic [4:0] OP_Z2         = 5'd9;
   localparam logic [4:0] OP_SDIV       = 5'd10;
   localparam logic [4:0] OP_SACC       = 5'd11;
   localparam logic [4:0] OP_TMUL       = 5'd12;
   localparam logic [4:0] OP_LOG        = 5'd13;
   localparam logic [4:0] OP_RDIV       = 5'd14;
   localparam logic [4:0] OP_RCAP       = 5'd15;
   localparam logic [4:0] OP_MUL_LO     = 5'd16;
   localparam logic [4:0] OP_MUL_HI     = 5'd17;
   localparam logic [4:0] OP_SQ_INIT    = 5'd18;
   localparam logic [4:0] OP_SQ_STEP    = 5'd19;
   localparam logic [4:0] OP_RES        = 5'd20;
   localparam logic [4:0] OP_TAKE       = 5'd21;

   typedef struct packed {
      logic [4:0] op;
      logic       val_sel;   // 0: first value of pair, 1: second
      logic [3:0] term;      // log series term index
      logic       out_load;
      logic       base_adv;
   } pnrg_cmd_type;

   typedef struct packed {
      logic a_ok;
      logic norm_done;
      logic div_busy;
   } pnrg_sts_type;

endpackage
`default_nettype wire

// File: rtl/core/pnrg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Shared by the log series, the z ratio and the per-value ratio. No dependencies.
`default_nettype none
module pnrg_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [29:0] num_hi,   // upper dividend part, must be below den
   input  wire logic [31:0] num_lo,   // lower dividend bits, msb first
   input  wire logic [29:0] den,
   input  wire logic [4:0]  count,    // quotient bits to produce
   output logic             busy,
   output logic [31:0]      quot
);

   logic        busy_ff, busy_in;
   logic [29:0] rem_ff, rem_in;
   logic [31:0] lo_ff, lo_in;
   logic [29:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quot_ff, quot_in;
   logic [30:0] cur;
   logic [30:0] diff;
   logic        ge;

   // trial subtract
   assign cur  = {rem_ff, lo_ff[31]};
   assign diff = cur - {1'b0, den_ff};
   assign ge   = cur >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = num_hi;
         lo_in   = num_lo;
         den_in  = den;
         cnt_in  = count;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[29:0] : cur[29:0];
         lo_in   = {lo_ff[30:0], 1'b0};
         quot_in = {quot_ff[30:0], ge};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

// File: rtl/core/pnrg_ctrl.sv
// Sequencer for the polar normal generator: handshakes, rejection loop,
// log series and per-value steps. Drives pnrg_dp through pnrg_pkg structs.
`default_nettype none
module pnrg_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_first_of_block,
   input  wire logic                 req_last_of_block,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire pnrg_pkg::pnrg_sts_type sts,
   output pnrg_pkg::pnrg_cmd_type    cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_STEP1 = 5'd1;
   localparam logic [4:0] S_STEP2 = 5'd2;
   localparam logic [4:0] S_SQ    = 5'd3;
   localparam logic [4:0] S_CHECK = 5'd4;
   localparam logic [4:0] S_NORM  = 5'd5;
   localparam logic [4:0] S_ZDIV  = 5'd6;
   localparam logic [4:0] S_ZWAIT = 5'd7;
   localparam logic [4:0] S_Z2    = 5'd8;
   localparam logic [4:0] S_SDIV  = 5'd9;
   localparam logic [4:0] S_SWAIT = 5'd10;
   localparam logic [4:0] S_TMUL  = 5'd11;
   localparam logic [4:0] S_LOG   = 5'd12;
   localparam logic [4:0] S_RDIV  = 5'd13;
   localparam logic [4:0] S_RWAIT = 5'd14;
   localparam logic [4:0] S_MLO   = 5'd15;
   localparam logic [4:0] S_MHI   = 5'd16;
   localparam logic [4:0] S_SQI   = 5'd17;
   localparam logic [4:0] S_SQS   = 5'd18;
   localparam logic [4:0] S_RES   = 5'd19;
   localparam logic [4:0] S_DONE  = 5'd20;

   logic [4:0]                 state_ff, state_in;
   logic                       pending_ff, pending_in;
   logic                       last_ff, last_in;
   logic                       sel_ff, sel_in;
   logic [3:0]                 term_ff, term_in;
   logic [pnrg_pkg::SQC_W-1:0] sqc_ff, sqc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       accept;
   logic                       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state and datapath command
   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      last_in      = last_ff;
      sel_in       = sel_ff;
      term_in      = term_ff;
      sqc_in       = sqc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.op       = pnrg_pkg::OP_NONE;
      cmd.val_sel  = sel_ff;
      cmd.term     = term_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in = req_last_of_block;
               if (req_first_of_block) begin
                  cmd.op = pnrg_pkg::OP_RELOAD;
               end
               if (pending_ff && !req_first_of_block) begin
                  cmd.op     = pnrg_pkg::OP_TAKE;
                  pending_in = 1'b0;
                  state_in   = S_DONE;
               end else begin
                  pending_in = 1'b0;
                  state_in   = S_STEP1;
               end
            end
         end
         S_STEP1: begin
            cmd.op   = pnrg_pkg::OP_STEP1;
            state_in = S_STEP2;
         end
         S_STEP2: begin
            cmd.op   = pnrg_pkg::OP_STEP2;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op   = pnrg_pkg::OP_SQ;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.a_ok) begin
               cmd.op   = pnrg_pkg::OP_NORM_INIT;
               state_in = S_NORM;
            end else begin
               state_in = S_STEP1;
            end
         end
         S_NORM: begin
            if (sts.norm_done) begin
               state_in = S_ZDIV;
            end else begin
               cmd.op = pnrg_pkg::OP_NORM_SHIFT;
            end
         end
         S_ZDIV: begin
            cmd.op   = pnrg_pkg::OP_ZDIV;
            state_in = S_ZWAIT;
         end
         S_ZWAIT: begin
            if (!sts.div_busy) begin
               cmd.op   = pnrg_pkg::OP_ZCAP;
               state_in = S_Z2;
            end
         end
         S_Z2: begin
            cmd.op   = pnrg_pkg::OP_Z2;
            term_in  = '0;
            state_in = S_SDIV;
         end
         S_SDIV: begin
            cmd.op   = pnrg_pkg::OP_SDIV;
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (!sts.div_busy) begin
               cmd.op   = pnrg_pkg::OP_SACC;
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            cmd.op = pnrg_pkg::OP_TMUL;
            if (term_ff == pnrg_pkg::LOG_LAST) begin
               state_in = S_LOG;
            end else begin
               term_in  = term_ff + 4'd1;
               state_in = S_SDIV;
            end
         end
         S_LOG: begin
            cmd.op   = pnrg_pkg::OP_LOG;
            sel_in   = 1'b0;
            state_in = S_RDIV;
         end
         S_RDIV: begin
            cmd.op   = pnrg_pkg::OP_RDIV;
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            if (!sts.div_busy) begin
               cmd.op   = pnrg_pkg::OP_RCAP;
               state_in = S_MLO;
            end
         end
         S_MLO: begin
            cmd.op   = pnrg_pkg::OP_MUL_LO;
            state_in = S_MHI;
         end
         S_MHI: begin
            cmd.op   = pnrg_pkg::OP_MUL_HI;
            state_in = S_SQI;
         end
         S_SQI: begin
            cmd.op   = pnrg_pkg::OP_SQ_INIT;
            sqc_in   = '0;
            state_in = S_SQS;
         end
         S_SQS: begin
            cmd.op = pnrg_pkg::OP_SQ_STEP;
            sqc_in = sqc_ff + 1'b1;
            if (sqc_ff == pnrg_pkg::SQ_LAST) begin
               state_in = S_RES;
            end
         end
         S_RES: begin
            cmd.op = pnrg_pkg::OP_RES;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = S_RDIV;
            end else begin
               pending_in = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.base_adv = last_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      sel_ff  <= sel_in;
      term_ff <= term_in;
      sqc_ff  <= sqc_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: rtl/core/pnrg_dp.sv
// Datapath of the polar normal generator: LCG, pair registers, log series,
// multiplies, bit-serial square root. Uses pnrg_pkg and pnrg_div.
`default_nettype none
module pnrg_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pnrg_pkg::pnrg_cmd_type      cmd,
   output pnrg_pkg::pnrg_sts_type           sts,
   input  wire logic                        seed_we,
   input  wire logic                        stride_we,
   input  wire logic [31:0]                 csr_data,
   output logic signed [pnrg_pkg::SAMPLE_W-1:0] rsp_sample
);

   localparam int RW = pnrg_pkg::ROOT_W;
   localparam int SW = pnrg_pkg::S_W;
   localparam int OW = pnrg_pkg::SAMPLE_W;
   localparam int PW = pnrg_pkg::PROD_W;

   // state and working registers
   logic [31:0]   lcg_ff, base_ff;
   logic [10:0]   stride_ff;
   logic          d1_neg_ff, d2_neg_ff;
   logic [14:0]   d1_mag_ff, d2_mag_ff;
   logic [29:0]   a_ff;
   logic [28:0]   m_ff;
   logic [4:0]    sh_ff;
   logic [29:0]   z_ff, z2_ff, t_ff;
   logic [33:0]   s_ff;
   logic [35:0]   l_ff;
   logic [28:0]   r_ff;
   logic [PW-1:0] prod_ff;
   logic [SW-1:0] sq_v_ff;
   logic [RW+1:0] sq_rem_ff;
   logic [RW-1:0] sq_root_ff;
   logic [OW-1:0] res_ff, held_ff, out_ff;

   // LCG step and centered draw
   logic [31:0] lcg_next;
   logic        cur_neg;
   logic [14:0] cur_mag;
   logic [29:0] sq_d1, sq_cur;
   assign lcg_next = lcg_ff * pnrg_pkg::LCG_MUL + pnrg_pkg::LCG_ADD;
   assign cur_neg  = !lcg_ff[30];
   assign cur_mag  = cur_neg ? (15'd16384 - {1'b0, lcg_ff[29:16]}) : {1'b0, lcg_ff[29:16]};
   assign sq_d1    = d1_mag_ff * d1_mag_ff;
   assign sq_cur   = cur_mag * cur_mag;

   // multiplies for the series
   logic [59:0] zz, tz;
   assign zz = z_ff * z_ff;
   assign tz = t_ff * z2_ff;

   // log combine: L = 2*(sh*ln2 - 2*s), floored at zero
   logic [34:0] pos, lnm;
   logic [35:0] l_val;
   assign pos   = sh_ff * pnrg_pkg::LN2_Q30;
   assign lnm   = {s_ff, 1'b0};
   assign l_val = (lnm >= pos) ? 36'd0 : {pos - lnm, 1'b0};

   // selected value of the pair
   logic        v_neg;
   logic [14:0] v_mag;
   logic [29:0] v_sq;
   assign v_neg = cmd.val_sel ? d2_neg_ff : d1_neg_ff;
   assign v_mag = cmd.val_sel ? d2_mag_ff : d1_mag_ff;
   assign v_sq  = v_mag * v_mag;

   // r * L in two partial products
   logic [46:0] pp_lo, pp_hi;
   assign pp_lo = r_ff * l_ff[17:0];
   assign pp_hi = r_ff * l_ff[35:18];

   // square root step
   logic [RW+3:0] sq_cur4, sq_trial, sq_diff;
   logic          sq_ge;
   assign sq_cur4  = {sq_rem_ff, sq_v_ff[SW-1 -: 2]};
   assign sq_trial = {2'b00, sq_root_ff, 2'b01};
   assign sq_ge    = sq_cur4 >= sq_trial;
   assign sq_diff  = sq_cur4 - sq_trial;

   // round to nearest, sign and saturate
   logic          rnd_up;
   logic [RW:0]   mag, mag_neg, mag_pos, neg_full;
   logic [OW-1:0] res_val;
   assign rnd_up   = sq_rem_ff > (RW + 2)'(sq_root_ff);
   assign mag      = (RW + 1)'(sq_root_ff) + (RW + 1)'(rnd_up);
   assign mag_neg  = (mag > pnrg_pkg::SAT_NEG) ? pnrg_pkg::SAT_NEG : mag;
   assign mag_pos  = (mag > pnrg_pkg::SAT_POS) ? pnrg_pkg::SAT_POS : mag;
   assign neg_full = -mag_neg;
   assign res_val  = v_neg ? neg_full[OW-1:0] : mag_pos[OW-1:0];

   // shared divider operands
   logic        div_start, div_busy;
   logic [29:0] div_hi, div_den;
   logic [31:0] div_lo, div_quot;
   logic [4:0]  div_cnt;

   always_comb begin
      div_start = 1'b0;
      div_hi    = '0;
      div_lo    = '0;
      div_den   = 30'd1;
      div_cnt   = pnrg_pkg::Z_BITS;
      case (cmd.op)
         pnrg_pkg::OP_ZDIV: begin
            div_start = 1'b1;
            div_hi    = {2'b00, m_ff[27:0]};
            div_den   = {1'b0, m_ff} + (30'd1 << 28);
         end
         pnrg_pkg::OP_SDIV: begin
            div_start = 1'b1;
            div_lo    = {t_ff, 2'b00};
            div_den   = {25'd0, cmd.term, 1'b1};
         end
         pnrg_pkg::OP_RDIV: begin
            div_start = 1'b1;
            div_hi    = {1'b0, v_sq[29:1]};
            div_lo    = {v_sq[0], 31'd0};
            div_den   = {2'b00, a_ff[27:0]};
            div_cnt   = pnrg_pkg::R_BITS;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   pnrg_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_hi (div_hi),
      .num_lo (div_lo),
      .den    (div_den),
      .count  (div_cnt),
      .busy   (div_busy),
      .quot   (div_quot)
   );

   // op execution
   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff    <= pnrg_pkg::SEED_RESET;
         base_ff   <= pnrg_pkg::SEED_RESET;
         stride_ff <= pnrg_pkg::STRIDE_RESET;
      end else begin
         if (seed_we) begin
            base_ff <= csr_data;
         end else if (cmd.base_adv) begin
            base_ff <= base_ff + {21'd0, stride_ff};
         end
         if (stride_we) begin
            stride_ff <= csr_data[10:0];
         end
         if (cmd.op == pnrg_pkg::OP_RELOAD) begin
            lcg_ff <= base_ff;
         end else if (cmd.op == pnrg_pkg::OP_STEP1 || cmd.op == pnrg_pkg::OP_STEP2) begin
            lcg_ff <= lcg_next;
         end
      end
      case (cmd.op)
         pnrg_pkg::OP_STEP2: begin
            d1_neg_ff <= cur_neg;
            d1_mag_ff <= cur_mag;
         end
         pnrg_pkg::OP_SQ: begin
            d2_neg_ff <= cur_neg;
            d2_mag_ff <= cur_mag;
            a_ff      <= sq_d1 + sq_cur;
         end
         pnrg_pkg::OP_NORM_INIT: begin
            m_ff  <= {1'b0, a_ff[27:0]};
            sh_ff <= '0;
         end
         pnrg_pkg::OP_NORM_SHIFT: begin
            m_ff  <= {m_ff[27:0], 1'b0};
            sh_ff <= sh_ff + 5'd1;
         end
         pnrg_pkg::OP_ZCAP: begin
            z_ff <= div_quot[29:0];
            t_ff <= div_quot[29:0];
            s_ff <= '0;
         end
         pnrg_pkg::OP_Z2: begin
            z2_ff <= zz[59:30];
         end
         pnrg_pkg::OP_SACC: begin
            s_ff <= s_ff + {4'd0, div_quot[29:0]};
         end
         pnrg_pkg::OP_TMUL: begin
            t_ff <= tz[59:30];
         end
         pnrg_pkg::OP_LOG: begin
            l_ff <= l_val;
         end
         pnrg_pkg::OP_RCAP: begin
            r_ff <= div_quot[28:0];
         end
         pnrg_pkg::OP_MUL_LO: begin
            prod_ff <= PW'(pp_lo);
         end
         pnrg_pkg::OP_MUL_HI: begin
            prod_ff <= prod_ff + (PW'(pp_hi) << 18);
         end
         pnrg_pkg::OP_SQ_INIT: begin
            sq_v_ff    <= prod_ff[PW-1:pnrg_pkg::S_SHIFT];
            sq_rem_ff  <= '0;
            sq_root_ff <= '0;
         end
         pnrg_pkg::OP_SQ_STEP: begin
            sq_v_ff    <= {sq_v_ff[SW-3:0], 2'b00};
            sq_rem_ff  <= sq_ge ? sq_diff[RW+1:0] : sq_cur4[RW+1:0];
            sq_root_ff <= {sq_root_ff[RW-2:0], sq_ge};
         end
         pnrg_pkg::OP_RES: begin
            if (cmd.val_sel) begin
               held_ff <= res_val;
            end else begin
               res_ff <= res_val;
            end
         end
         pnrg_pkg::OP_TAKE: begin
            res_ff <= held_ff;
         end
         default: begin
         end
      endcase
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
   end

   assign sts.a_ok      = (a_ff[29:28] == 2'b00) && (a_ff[27:0] != 28'd0);
   assign sts.norm_done = m_ff[28];
   assign sts.div_busy  = div_busy;
   assign rsp_sample    = $signed(out_ff);

endmodule
`default_nettype wire

// File: rtl/core/polar_normal_random_generator_unit.sv
// Polar-method normal generator. One request at a time. A request served from
// the held second value of a pair goes to the output register through S_DONE; a
// fresh pair runs rejection tries, normalize shifts and the log series, whose cost
// is mostly its twelve 30-bit serial divisions in the shared one-bit-per-cycle
// divider. Two samples share that cost. Synchronous active-high reset: seed 3,
// stride 4, no held sample; the output register frees the input side.
`default_nettype none
module polar_normal_random_generator_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_first_of_block,
   input  wire logic                             req_last_of_block,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [pnrg_pkg::SAMPLE_W-1:0]  rsp_sample,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [31:0]                      csr_data
);

   pnrg_pkg::pnrg_cmd_type cmd;
   pnrg_pkg::pnrg_sts_type sts;
   logic seed_we, stride_we;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign seed_we   = csr_valid && (csr_index == pnrg_pkg::CSR_SEED);
   assign stride_we = csr_valid && (csr_index == pnrg_pkg::CSR_STRIDE);

   pnrg_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_of_block (req_first_of_block),
      .req_last_of_block  (req_last_of_block),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .sts                (sts),
      .cmd                (cmd)
   );

   pnrg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .seed_we    (seed_we),
      .stride_we  (stride_we),
      .csr_data   (csr_data),
      .rsp_sample (rsp_sample)
   );

endmodule
`default_nettype wire

// File: rtl/core/pnrg_checker.sv
// Port-level checker for the polar normal generator, bound to the top level.
// Uses the assertion macros header and pnrg_pkg.
`default_nettype none
`include "polar_normal_random_generator_unit_assert.svh"
module pnrg_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [pnrg_pkg::SAMPLE_W-1:0]    rsp_sample
);

   // a stalled result beat stays and holds its value
   `PNRG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `PNRG_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_sample))

   // one request in flight: an accepted beat closes the input side
   `PNRG_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

   // a new result comes with the input side open again
   `PNRG_ASSERT_NOW(a_result_frees_input, $rose(rsp_valid), !req_stall)

endmodule

bind polar_normal_random_generator_unit pnrg_checker u_checker (.*);
`default_nettype wire

// File: verif/polar_normal_random_generator_unit_tb.sv
// Self-checking testbench for polar_normal_random_generator_unit.
// Depends on pnrg_pkg and the unit; holds its own bit-exact polar-method predictor.
`default_nettype none
module polar_normal_random_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;
   localparam int CYCLE_LIMIT = 6000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_stall;
   logic req_first_of_block = 1'b0, req_last_of_block = 1'b0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic signed [pnrg_pkg::SAMPLE_W-1:0] rsp_sample;
   logic csr_valid = 1'b0, csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   polar_normal_random_generator_unit dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] base_seed, lcg_word;
   logic [10:0] stride_reg;
   bit pair_held;
   logic [pnrg_pkg::SAMPLE_W-1:0] held_value;
   logic [pnrg_pkg::SAMPLE_W-1:0] sample_queue[$];

   int errors = 0;
   int cycles = 0;
   bit idle_on = 1'b1;
   int hold_off = 0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   // next uniform, centered on zero
   function automatic int draw_centered();
      lcg_word = lcg_word * pnrg_pkg::LCG_MUL + pnrg_pkg::LCG_ADD;
      return int'((lcg_word >> 16) & 32'h7FFF) - 16384;
   endfunction

   // -2 ln(A/2^28) in Q30
   function automatic longint unsigned neg_two_ln(input longint unsigned big_a);
      longint unsigned m, z, z2, t, s, lnm, pos;
      int e;
      e = 0;
      s = 0;
      while (e < 27 && (big_a >> (e + 1)) != 0) e++;
      m = big_a << (28 - e);
      z = ((m - (64'd1 << 28)) << 30) / (m + (64'd1 << 28));
      z2 = (z * z) >> 30;
      t = z;
      for (int j = 0; j < 12; j++) begin
         s += t / longint'(2 * j + 1);
         t = (t * z2) >> 30;
      end
      lnm = 2 * s;
      pos = longint'(28 - e) * 64'd744261118;
      if (lnm >= pos) return 0;
      return 2 * (pos - lnm);
   endfunction

   function automatic longint unsigned root_nearest(input longint unsigned v);
      longint unsigned q, bitv, rem;
      q = 0;
      bitv = 64'd1 << 62;
      rem = v;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= q + bitv) begin
            rem -= q + bitv;
            q = (q >> 1) + bitv;
         end else begin
            q >>= 1;
         end
         bitv >>= 2;
      end
      if (v - q * q > q) q++;
      return q;
   endfunction

   function automatic logic [pnrg_pkg::SAMPLE_W-1:0] scale_value(input int d,
         input longint unsigned big_a, input longint unsigned lq);
      longint unsigned mag, r, s, q, lim;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      r = ((mag * mag) << 28) / big_a;
      s = (r * lq) >> (58 - 2 * pnrg_pkg::FRAC_W);
      q = root_nearest(s);
      lim = 64'd1 << (pnrg_pkg::FRAC_W + 3);
      if (d < 0) begin
         if (q > lim) q = lim;
         return pnrg_pkg::SAMPLE_W'(-q);
      end
      if (q > lim - 1) q = lim - 1;
      return pnrg_pkg::SAMPLE_W'(q);
   endfunction

   // expected sample for one request beat
   function automatic logic [pnrg_pkg::SAMPLE_W-1:0] next_sample(input bit first,
         input bit last);
      logic [pnrg_pkg::SAMPLE_W-1:0] res;
      int d1, d2;
      longint unsigned big_a, lq;
      if (first) begin
         lcg_word = base_seed;
         pair_held = 0;
         held_value = '0;
      end
      if (pair_held) begin
         res = held_value;
         pair_held = 0;
      end else begin
         forever begin
            d1 = draw_centered();
            d2 = draw_centered();
            big_a = longint'(d1 * d1) + longint'(d2 * d2);
            if (big_a != 0 && big_a < (64'd1 << 28)) break;
         end
         lq = neg_two_ln(big_a);
         res = scale_value(d1, big_a, lq);
         held_value = scale_value(d2, big_a, lq);
         pair_held = 1;
      end
      if (last) base_seed += 32'(stride_reg);
      return res;
   endfunction

   // one request beat, at times with a random gap before it
   task automatic send_request(input bit first, input bit last);
      if (idle_on && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_of_block <= first;
      req_last_of_block <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sample_queue.push_back(next_sample(first, last));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sample_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (idx == pnrg_pkg::CSR_SEED) begin
         base_seed = value;
      end else if (idx == pnrg_pkg::CSR_STRIDE) begin
         stride_reg = value[10:0];
      end
   endtask

   // result beats checked against the oldest expectation
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sample_queue.size() == 0) begin
            report($sformatf("unexpected sample %0d", rsp_sample));
         end else begin
            if (rsp_sample !== sample_queue[0])
               report($sformatf("sample got %h want %h", rsp_sample, sample_queue[0]));
            void'(sample_queue.pop_front());
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stall: random, or a long hold-off
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 19);
      end
   end

   task automatic test_directed();
      send_request(1, 0);
      send_request(0, 0);
      send_request(0, 0);
      send_request(0, 1);
      send_request(1, 1);
      send_request(1, 1);
      send_request(0, 0);
      send_request(1, 0);
      send_request(1, 0);
      send_request(0, 1);
      send_request(0, 1);
   endtask

   task automatic test_register_extremes();
      write_csr(pnrg_pkg::CSR_STRIDE, 32'd0);
      write_csr(pnrg_pkg::CSR_SEED, 32'hFFFF_FFFF);
      send_request(1, 1);
      send_request(1, 1);
      send_request(0, 0);
      write_csr(pnrg_pkg::CSR_SEED, 32'd0);
      write_csr(pnrg_pkg::CSR_STRIDE, 32'h7FF);
      send_request(1, 1);
      send_request(1, 0);
      write_csr(pnrg_pkg::CSR_SEED, 32'h8000_0000);
      write_csr(pnrg_pkg::CSR_STRIDE, 32'd1);
      write_csr(CSR_SPARE_A, 32'hDEAD_BEEF);
      write_csr(CSR_SPARE_B, 32'h1234_5678);
      send_request(1, 1);
      send_request(1, 0);
      send_request(0, 1);
      write_csr(pnrg_pkg::CSR_SEED, 32'hFFFF_FFF0);
      write_csr(pnrg_pkg::CSR_STRIDE, 32'd1024);
      send_request(1, 1);
      send_request(1, 1);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 3) idle_on = 1'b0;
         if (i == count / 2) idle_on = 1'b1;
         if (i % 200 == 199) begin
            write_csr(pnrg_pkg::CSR_SEED, $urandom());
            write_csr(pnrg_pkg::CSR_STRIDE, $urandom_range(2047));
         end
         send_request($urandom_range(99) < 15, $urandom_range(99) < 15);
      end
   endtask

   task automatic test_backpressure();
      drain();
      hold_off = 3000;
      for (int i = 0; i < 12; i++) send_request(i == 0, 0);
   endtask

   initial begin
      base_seed = pnrg_pkg::SEED_RESET;
      lcg_word = pnrg_pkg::SEED_RESET;
      stride_reg = pnrg_pkg::STRIDE_RESET;
      pair_held = 0;
      held_value = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random(800);
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0 && sample_queue.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
`default_nettype wire
